@@ sv/swdt_pkg.sv @@
// ----------------------------------------------------------------------------
// swdt_pkg: sliding window duration throttle package
// Field widths, status codes, config indexes and the controller state type.
// ----------------------------------------------------------------------------
package swdt_pkg;

    localparam int TIME_W    = 48;
    localparam int DUR_W     = 24;
    localparam int WIN_W     = 24;
    localparam int MAXD_W    = 28;
    localparam int STATUS_W  = 2;
    localparam int DELAY_W   = 30;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 28;

    localparam int LOG_DEPTH_DEF = 64;

    // window total never exceeds a limit that was in force at grant time
    localparam int TOTAL_W = MAXD_W;

    localparam logic [WIN_W-1:0]  WINDOW_RST = WIN_W'(1000000);
    localparam logic [MAXD_W-1:0] MAXD_RST   = MAXD_W'(2000000);

    localparam logic [STATUS_W-1:0] STATUS_GRANT = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DEFER = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXDUR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPIRE,
        ST_DECIDE
    } state_t;

endpackage

@@ sv/swdt_if.sv @@
// ----------------------------------------------------------------------------
// swdt_if: request, response and config channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface swdt_req_if;
    logic                       valid;
    logic                       ready;
    logic [swdt_pkg::TIME_W-1:0] now_us;
    logic [swdt_pkg::DUR_W-1:0]  duration_us;

    modport source (output valid, output now_us, output duration_us, input ready);
    modport sink   (input valid, input now_us, input duration_us, output ready);
endinterface

interface swdt_res_if;
    logic                         valid;
    logic                         ready;
    logic [swdt_pkg::STATUS_W-1:0] status;
    logic [swdt_pkg::DELAY_W-1:0]  delay_us;

    modport source (output valid, output status, output delay_us, input ready);
    modport sink   (input valid, input status, input delay_us, output ready);
endinterface

interface swdt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [swdt_pkg::CFG_IDX_W-1:0] index;
    logic [swdt_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/sliding_window_duration_throttle_core.sv @@
// ----------------------------------------------------------------------------
// sliding_window_duration_throttle_core: sliding window admission control
// Logs granted requests in a ring memory and limits summed duration per window.
// ----------------------------------------------------------------------------
// Usage:
//   req : one request per transfer, arrival time now_us and duration_us.
//   res : one response per request, status (grant/defer/full) and delay_us.
//   cfg : register writes, index 0 = window_us, index 1 = max_duration_us.
//         Always ready; write only while no request is in flight.
// Flow: a request is taken only in the idle state. With a non-empty log
//   the expire step drops expired entries from the oldest end until a live
//   entry is found or the log empties; the decide step then registers the
//   response and returns to idle, so one request is processed at a time.
// Reset: log empty, window total zero, registers at 1 s window and 2 s limit.
//   The ring memory is not cleared; only entries inside the count are read.
// Stall: the response sits in an output register. A new request is taken
//   while it waits; that request then holds in the decide step until res
//   drains, and req.ready stays low meanwhile.
// ----------------------------------------------------------------------------
module sliding_window_duration_throttle_core #(
    parameter int LOG_DEPTH = swdt_pkg::LOG_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    swdt_req_if.sink        req,
    swdt_res_if.source      res,
    swdt_cfg_if.sink        cfg
);

    localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W = $clog2(LOG_DEPTH + 1);
    localparam int ENT_W = swdt_pkg::TIME_W + swdt_pkg::DUR_W;
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(LOG_DEPTH - 1);
    localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(LOG_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LOG_DEPTH);

    // control state
    swdt_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [swdt_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [swdt_pkg::WIN_W-1:0]   window_reg;
    logic [swdt_pkg::MAXD_W-1:0]  maxd_reg;
    logic               res_valid_reg, res_valid_next;

    // request / response payload
    logic [swdt_pkg::TIME_W-1:0]   now_reg;
    logic [swdt_pkg::DUR_W-1:0]    dur_reg;
    logic [swdt_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [swdt_pkg::DELAY_W-1:0]  delay_reg, delay_next;
    logic                          res_load;

    // ring memory, entry = {grant time, grant duration}
    logic [ENT_W-1:0]   mem [LOG_DEPTH];
    logic [ENT_W-1:0]   rd_data_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;

    // datapath
    logic [swdt_pkg::TIME_W-1:0] ent_time;
    logic [swdt_pkg::DUR_W-1:0]  ent_dur;
    logic [swdt_pkg::TIME_W:0]   ent_limit;
    logic                        expired;
    logic [IDX_W-1:0]            head_inc;
    logic [CNT_W:0]              tail_sum;
    logic [swdt_pkg::TOTAL_W:0]  req_total;
    logic                        over;
    logic [swdt_pkg::TOTAL_W:0]  excess;
    logic                        req_fire;

    assign req_fire = req.valid && req.ready;

    assign ent_time  = rd_data_reg[ENT_W-1 -: swdt_pkg::TIME_W];
    assign ent_dur   = rd_data_reg[swdt_pkg::DUR_W-1:0];
    // entry expires when time + window < now
    assign ent_limit = {1'b0, ent_time} + {{(swdt_pkg::TIME_W + 1 - swdt_pkg::WIN_W){1'b0}},
                                           window_reg};
    assign expired   = ent_limit < {1'b0, now_reg};
    assign head_inc  = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;

    // tail = (head + count) mod depth, sum stays below twice the depth
    assign tail_sum  = {{(CNT_W + 1 - IDX_W){1'b0}}, head_reg} + {1'b0, count_reg};
    assign wr_addr   = (tail_sum >= DEPTH_EXT) ? IDX_W'(tail_sum - DEPTH_EXT)
                                               : IDX_W'(tail_sum);

    assign req_total = {1'b0, total_reg}
                     + {{(swdt_pkg::TOTAL_W + 1 - swdt_pkg::DUR_W){1'b0}}, dur_reg};
    assign over      = req_total > {1'b0, maxd_reg};
    assign excess    = req_total - {1'b0, maxd_reg};

    assign req.ready = (state_reg == swdt_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;
    assign res.valid    = res_valid_reg;
    assign res.status   = status_reg;
    assign res.delay_us = delay_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        res_valid_next = res_valid_reg && !res.ready;
        status_next    = status_reg;
        delay_next     = delay_reg;
        res_load       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        wr_en          = 1'b0;

        case (state_reg)
            swdt_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    // fetch the oldest entry while the request is latched
                    rd_en = 1'b1;
                    if (count_reg != '0)
                        state_next = swdt_pkg::ST_EXPIRE;
                    else
                        state_next = swdt_pkg::ST_DECIDE;
                end
            end
            swdt_pkg::ST_EXPIRE:
            begin
                if (expired)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    total_next = total_reg
                               - {{(swdt_pkg::TOTAL_W - swdt_pkg::DUR_W){1'b0}}, ent_dur};
                    rd_en      = 1'b1;
                    rd_addr    = head_inc;
                    if (count_reg == CNT_W'(1))
                        state_next = swdt_pkg::ST_DECIDE;
                end
                else
                begin
                    state_next = swdt_pkg::ST_DECIDE;
                end
            end
            swdt_pkg::ST_DECIDE:
            begin
                // wait here until the output register is free
                if (!res_valid_reg || res.ready)
                begin
                    res_load       = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = swdt_pkg::ST_IDLE;
                    if (over)
                    begin
                        status_next = swdt_pkg::STATUS_DEFER;
                        delay_next  = {{(swdt_pkg::DELAY_W - swdt_pkg::TOTAL_W - 1){1'b0}},
                                       excess};
                    end
                    else if (count_reg == DEPTH_CNT)
                    begin
                        status_next = swdt_pkg::STATUS_FULL;
                        delay_next  = '0;
                    end
                    else
                    begin
                        status_next = swdt_pkg::STATUS_GRANT;
                        delay_next  = '0;
                        wr_en       = 1'b1;
                        count_next  = count_reg + 1'b1;
                        total_next  = req_total[swdt_pkg::TOTAL_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = swdt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swdt_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
            window_reg    <= swdt_pkg::WINDOW_RST;
            maxd_reg      <= swdt_pkg::MAXD_RST;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    swdt_pkg::CFG_WINDOW: window_reg <= cfg.data[swdt_pkg::WIN_W-1:0];
                    swdt_pkg::CFG_MAXDUR: maxd_reg   <= cfg.data[swdt_pkg::MAXD_W-1:0];
                    default:              ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            now_reg <= req.now_us;
            dur_reg <= req.duration_us;
        end
        if (res_load)
        begin
            status_reg <= status_next;
            delay_reg  <= delay_next;
        end
    end

    // ring memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {now_reg, dur_reg};
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: sliding window duration throttle core
// Drives timed requests against the core and scores every response against
// a local admission predictor: a ring log of grants, expiry, limit and full.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOG_DEPTH = swdt_pkg::LOG_DEPTH_DEF;
    localparam int PROBES = 16;
    localparam int PHASES = 7;
    localparam int REQS_PER_PHASE = 193;
    localparam int VERDICT_SLOTS = 16;
    localparam longint unsigned DELAY_CAP = (64'd1 << swdt_pkg::DELAY_W) - 1;

    // one response as the core should report it
    typedef struct packed {
        logic [swdt_pkg::STATUS_W-1:0] status;
        logic [swdt_pkg::DELAY_W-1:0]  delay;
    } verdict_t;

    // one request; fixed rows carry a hand-written verdict
    typedef struct packed {
        logic [swdt_pkg::TIME_W-1:0]   now;
        logic [swdt_pkg::DUR_W-1:0]    dur;
        logic                          fixed;
        logic [swdt_pkg::STATUS_W-1:0] status;
        logic [swdt_pkg::DELAY_W-1:0]  delay;
    } probe_t;

    logic clk = 1'b0;
    logic rst_n;

    swdt_req_if req ();
    swdt_res_if res ();
    swdt_cfg_if cfg ();

    sliding_window_duration_throttle_core #(
        .LOG_DEPTH (LOG_DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res),
        .cfg   (cfg)
    );

    // ------------------------------------------------------------------
    // Admission predictor state: its own grant ring and register copies
    // ------------------------------------------------------------------
    logic [swdt_pkg::TIME_W-1:0] grant_at   [LOG_DEPTH];
    logic [swdt_pkg::DUR_W-1:0]  grant_len  [LOG_DEPTH];
    int unsigned       ring_head;
    int unsigned       ring_fill;
    longint unsigned   logged_sum;
    logic [swdt_pkg::WIN_W-1:0]  window_reg;
    logic [swdt_pkg::MAXD_W-1:0] limit_reg;

    // expected responses in request order; written by the sender,
    // read by the scoreboard
    verdict_t    verdict_ring [VERDICT_SLOTS];
    int unsigned verdict_wr = 0;
    int unsigned verdict_rd = 0;

    int unsigned err_count = 0;
    int unsigned accepted;
    int unsigned burst_left;
    logic        recv_hold = 1'b0;

    probe_t                      probes        [PROBES];
    logic [swdt_pkg::WIN_W-1:0]  phase_window  [PHASES];
    logic [swdt_pkg::MAXD_W-1:0] phase_limit   [PHASES];

    always #5 clk = ~clk;

    // Drop expired grants from the oldest end, then grant, defer or refuse.
    // Expiry compares at 64 bits so a time near the top of the 48-bit range
    // plus the window does not wrap.
    task automatic admit_request(input logic [swdt_pkg::TIME_W-1:0] now,
                                 input logic [swdt_pkg::DUR_W-1:0] dur,
                                 output verdict_t v);
        longint unsigned sum;
        int unsigned     tail;
        while (ring_fill != 0 &&
               64'(grant_at[ring_head]) + 64'(window_reg) < 64'(now))
        begin
            logged_sum -= grant_len[ring_head];
            ring_head = (ring_head + 1) % LOG_DEPTH;
            ring_fill--;
        end
        sum = logged_sum + dur;
        v.delay = '0;
        if (sum > limit_reg)
        begin
            // over limit wins over a full log
            v.status = swdt_pkg::STATUS_DEFER;
            v.delay = (sum - limit_reg > DELAY_CAP) ? swdt_pkg::DELAY_W'(DELAY_CAP)
                                                    : swdt_pkg::DELAY_W'(sum - limit_reg);
        end
        else if (ring_fill >= LOG_DEPTH)
        begin
            v.status = swdt_pkg::STATUS_FULL;
        end
        else
        begin
            tail = (ring_head + ring_fill) % LOG_DEPTH;
            grant_at[tail] = now;
            grant_len[tail] = dur;
            ring_fill++;
            logged_sum = sum;
            v.status = swdt_pkg::STATUS_GRANT;
        end
    endtask

    // Sender: bursts of random length, random gaps between them. Valid is
    // only lowered when a gap follows, never toggled within one edge.
    task automatic offer_request(input probe_t p);
        int unsigned gap;
        verdict_t    v;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16)
                                              : $urandom_range(1, 3);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        req.valid       <= 1'b1;
        req.now_us      <= p.now;
        req.duration_us <= p.dur;
        do
            @(posedge clk);
        while (!req.ready);
        // accepted at this edge: predict now, before the response can appear
        admit_request(p.now, p.dur, v);
        if (p.fixed)
        begin
            v.status = p.status;
            v.delay = p.delay;
        end
        verdict_ring[verdict_wr % VERDICT_SLOTS] = v;
        verdict_wr++;
        accepted++;
    endtask

    // Leaves valid high; the caller lowers it after the last write.
    task automatic write_register(input logic [swdt_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [swdt_pkg::CFG_DAT_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (idx == swdt_pkg::CFG_WINDOW)
            window_reg = data[swdt_pkg::WIN_W-1:0];
        else
            limit_reg = data[swdt_pkg::MAXD_W-1:0];
    endtask

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        err_count++;
        if (err_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Response scoreboard: in-order compare against the oldest verdict
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : score_responses
        verdict_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (verdict_wr == verdict_rd)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("response with no request pending: status %0d delay %0d",
                             res.status, res.delay_us);
            end
            else
            begin
                want = verdict_ring[verdict_rd % VERDICT_SLOTS];
                verdict_rd++;
                if (res.status !== want.status)
                    report_mismatch("status", want.status, res.status);
                if (res.delay_us !== want.delay)
                    report_mismatch("delay_us", want.delay, res.delay_us);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver pacing: a mode is held for a random stretch; recv_hold
    // overrides everything for the long back-pressure windows.
    // ------------------------------------------------------------------
    int unsigned recv_mode = 0;
    int unsigned recv_left = 0;
    int unsigned recv_tick = 0;
    logic        recv_go;

    always @(posedge clk)
    begin : pace_receiver
        if (recv_left == 0)
        begin
            recv_mode = $urandom_range(0, 3);
            recv_left = $urandom_range(50, 300);
        end
        else
        begin
            recv_left--;
        end
        recv_tick++;
        case (recv_mode)
            0: recv_go = 1'b1;                              // no stalls at all
            1: recv_go = ($urandom_range(0, 3) != 0);
            2: recv_go = 1'($urandom_range(0, 1));
            default: recv_go = (recv_tick % 7) >= 3;        // fixed duty pattern
        endcase
        res.ready <= recv_go && !recv_hold;
    end

    // Long receiver hold-offs while the sender keeps offering: the core
    // parks one request behind the waiting response and drops req.ready.
    initial
    begin : back_pressure
        int i;
        for (i = 0; i < 2; i++)
        begin
            wait (accepted >= 250 + i * 650);
            @(posedge clk);
            recv_hold <= 1'b1;
            repeat (400) @(posedge clk);
            recv_hold <= 1'b0;
        end
    end

    // Guard against a hung core
    initial
    begin
        #10ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int          ph;
        int          k;
        int unsigned r;
        int unsigned fill_left;
        bit          overload_next;
        longint unsigned span;
        logic [swdt_pkg::TIME_W-1:0] now;
        logic [swdt_pkg::DUR_W-1:0]  dur;

        rst_n = 1'b0;
        req.valid = 1'b0;
        req.now_us = '0;
        req.duration_us = '0;
        cfg.valid = 1'b0;
        cfg.index = swdt_pkg::CFG_WINDOW;
        cfg.data = '0;
        accepted = 0;
        burst_left = 0;
        ring_head = 0;
        ring_fill = 0;
        logged_sum = 0;
        window_reg = swdt_pkg::WINDOW_RST;
        limit_reg = swdt_pkg::MAXD_RST;

        // Directed requests at the reset window (1 s) and limit (2 s).
        probes = '{
            // early time, nothing to expire, zero duration
            '{48'd0,             24'd0,        1'b1, swdt_pkg::STATUS_GRANT, 30'd0},
            // largest duration alone is over the limit
            '{48'd0,             24'hFFFFFF,   1'b1, swdt_pkg::STATUS_DEFER, 30'd14777215},
            // total lands exactly on the limit
            '{48'd10,            24'd2000000,  1'b1, swdt_pkg::STATUS_GRANT, 30'd0},
            '{48'd20,            24'd1,        1'b1, swdt_pkg::STATUS_DEFER, 30'd1},
            // grant at 10 is exactly window old, not strictly older: kept
            '{48'd1000010,       24'd1,        1'b1, swdt_pkg::STATUS_DEFER, 30'd1},
            '{48'd1000011,       24'd0,        1'b1, swdt_pkg::STATUS_GRANT, 30'd0},
            // time going backwards: only the oldest entry is tested
            '{48'd5,             24'd1,        1'b0, swdt_pkg::STATUS_GRANT, 30'd0},
            '{48'd2000012,       24'd0,        1'b0, swdt_pkg::STATUS_GRANT, 30'd0},
            // top of the time range: time plus window must not wrap
            '{48'hFFFFFFFFFFFF,  24'hFFFFFF,   1'b0, swdt_pkg::STATUS_GRANT, 30'd0},
            '{48'hFFFFFFFFFFFF,  24'd1999999,  1'b0, swdt_pkg::STATUS_GRANT, 30'd0},
            '{48'hFFFFFFFFFFFF,  24'd1,        1'b0, swdt_pkg::STATUS_GRANT, 30'd0},
            '{48'hFFFFFFFFFFFF,  24'd2,        1'b0, swdt_pkg::STATUS_GRANT, 30'd0},
            '{48'd0,             24'd0,        1'b0, swdt_pkg::STATUS_GRANT, 30'd0},
            '{48'h555555555555,  24'hAAAAAA,   1'b0, swdt_pkg::STATUS_GRANT, 30'd0},
            '{48'hAAAAAAAAAAAA,  24'h555555,   1'b0, swdt_pkg::STATUS_GRANT, 30'd0},
            '{48'hAAAAAAAAAAAA,  24'd1,        1'b0, swdt_pkg::STATUS_GRANT, 30'd0}
        };

        // Register settings per random phase: extremes, zeros, then typical.
        phase_window = '{24'hFFFFFF, 24'd1, 24'd0, 24'hFFFFFF, 24'd1,
                         24'd5000, 24'd1000000};
        phase_limit  = '{28'hFFFFFFF, 28'd1, 28'd0, 28'd1, 28'hFFFFFFF,
                         28'd300000, 28'd2000000};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < PROBES; k++)
            offer_request(probes[k]);
        now = 48'hAAAAAAAAAAAA;

        for (ph = 0; ph < PHASES; ph++)
        begin
            // registers change only with nothing in flight: every response
            // drained, then some idle cycles on top
            req.valid <= 1'b0;
            burst_left = 0;
            while (verdict_wr != verdict_rd)
                @(posedge clk);
            repeat (LOG_DEPTH + 8) @(posedge clk);
            write_register(swdt_pkg::CFG_WINDOW,
                           swdt_pkg::CFG_DAT_W'(phase_window[ph]));
            write_register(swdt_pkg::CFG_MAXDUR, phase_limit[ph]);
            cfg.valid <= 1'b0;

            // even phases open with a fill run: same time, zero duration,
            // enough requests to fill the log and hit the full status
            fill_left = (ph % 2 == 0) ? $urandom_range(LOG_DEPTH, LOG_DEPTH + 6) : 0;
            overload_next = 1'b0;

            for (k = 0; k < REQS_PER_PHASE; k++)
            begin
                if (fill_left == 0 && !overload_next && $urandom_range(0, 299) == 0)
                    fill_left = $urandom_range(LOG_DEPTH, LOG_DEPTH + 6);

                if (fill_left != 0)
                begin
                    dur = '0;
                    fill_left--;
                    overload_next = (fill_left == 0);
                end
                else if (overload_next)
                begin
                    // full log plus a huge duration: over limit takes precedence
                    // unless the limit swallows it, then it is refused as full
                    dur = '1;
                    overload_next = 1'b0;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        now = {16'($urandom), 32'($urandom)};   // jump, often backwards
                    else if (r >= 15)
                        now = now + $urandom_range(0, (window_reg >> 2) + 2);

                    r = $urandom_range(0, 99);
                    if (r < 10)
                        dur = '0;
                    else if (r < 20)
                        dur = swdt_pkg::DUR_W'($urandom);
                    else
                    begin
                        // scale to the limit so grants and deferrals both occur
                        span = (64'(limit_reg) >> $urandom_range(1, 5)) + 1;
                        if (span > 64'hFFFFFF)
                            span = 64'hFFFFFF;
                        dur = swdt_pkg::DUR_W'($urandom_range(0, 32'(span)));
                    end
                end
                offer_request('{now, dur, 1'b0, swdt_pkg::STATUS_GRANT, 30'd0});
            end
        end

        req.valid <= 1'b0;
        while (verdict_wr != verdict_rd)
            @(posedge clk);
        repeat (LOG_DEPTH + 10) @(posedge clk);

        if (err_count == 0 && verdict_wr == verdict_rd)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sliding_window_duration_throttle_core.f @@
sv/swdt_pkg.sv
sv/swdt_if.sv
sv/sliding_window_duration_throttle_core.sv
sim/testbench.sv
